FILE: hw/rtl/lgs_pkg.sv
// Shared types, codes and constants of the life grid generation step block.
package lgs_pkg;

	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] GRID_SIZE_RST = 7'd64;

	localparam int MAX_COLS_DEF = 64;
	localparam int MAX_ROWS_DEF = 64;

	// B3/S23: born with three live neighbors, survives with two or three.
	localparam logic [3:0] BIRTH_COUNT   = 4'd3;
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_READ  = 2'd1,
		ACT_STEP  = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef struct packed {
		action_t    action;
		logic [5:0] col_x;
		logic [5:0] row_y;
		logic       cell_value;
	} req_t;

	typedef struct packed {
		logic read_alive;
		logic coord_ok;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CELL_RD,
		ST_CELL_WB,
		ST_STEP,
		ST_FINISH
	} state_t;

endpackage

FILE: hw/rtl/life_grid_generation_step.sv
// Top level of the life grid generation step block: sequencer, row window and grid storage.
// The grid lives in a RAM of MAX_ROWS rows of MAX_COLS bits with one valid flop per row, so a
// clear takes effect at once and the block needs no clearing pass after reset. One item is worked on at
// a time and req_ready is high only when the sequencer is idle; a finished result sits in the output
// register while the next item is taken. A cell write or read passes through a RAM read state and a
// write-back state (only a write stores a row there); a clear or an out-of-range access goes straight
// to the finish state. In an advance the single row unit computes one whole row per cycle as the rows
// stream out of the RAM read port through a three-row window and are written back one row behind.
module life_grid_generation_step #(
	parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = lgs_pkg::MAX_ROWS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  lgs_pkg::req_t                  req,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output lgs_pkg::rsp_t                  rsp,
	input  logic                           cfg_we,
	input  logic [lgs_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [lgs_pkg::CFG_W-1:0]      cfg_wdata
);

	localparam int CAW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int UCW  = ($clog2(MAX_COLS + 1) > lgs_pkg::CFG_W) ?
		$clog2(MAX_COLS + 1) : lgs_pkg::CFG_W;
	localparam int URW  = ($clog2(MAX_ROWS + 1) > lgs_pkg::CFG_W) ?
		$clog2(MAX_ROWS + 1) : lgs_pkg::CFG_W;
	localparam int RCW  = URW + 1;

	lgs_pkg::state_t state_q, state_d;

	logic [lgs_pkg::CFG_W-1:0] grid_w_q, grid_h_q;
	logic [UCW-1:0]            used_cols;
	logic [URW-1:0]            used_rows;
	logic [MAX_COLS-1:0]       col_mask;
	logic                      coord_in;
	logic                      acc;
	logic                      ok_now;

	lgs_pkg::req_t             item_q;
	logic                      res_alive_q, res_ok_q;
	logic [UCW-1:0]            col_ext;
	logic [URW-1:0]            row_ext;
	logic [CAW-1:0]            col_idx;
	logic [AW-1:0]             row_idx;

	logic [MAX_ROWS-1:0]       row_vld_q;
	logic [RCW-1:0]            rd_cnt_q;
	logic                      rd_issue;
	logic                      rd_v_s1;
	logic [RCW-1:0]            rd_idx_s1;
	logic                      vld_s1;
	logic                      win_v_s2;
	logic [RCW-1:0]            win_idx_s2;
	logic [MAX_COLS-1:0]       win_prev_q, win_cur_q, win_next_q;
	logic [MAX_COLS-1:0]       new_row;
	logic [MAX_COLS-1:0]       row_old, row_win, row_mod;
	logic [RCW-1:0]            wr_idx;
	logic                      step_done;

	logic                      ram_we;
	logic [AW-1:0]             ram_waddr, ram_raddr;
	logic [MAX_COLS-1:0]       ram_wdata, ram_rdata;
	logic                      rsp_load;
	logic                      rsp_valid_q;
	lgs_pkg::rsp_t             rsp_q;

	// Used size saturates at the built maximum.
	always_comb begin
		used_cols = (UCW'(grid_w_q) > UCW'(MAX_COLS)) ? UCW'(MAX_COLS) : UCW'(grid_w_q);
		used_rows = (URW'(grid_h_q) > URW'(MAX_ROWS)) ? URW'(MAX_ROWS) : URW'(grid_h_q);
		for (int c = 0; c < MAX_COLS; c++) begin
			col_mask[c] = (UCW'(c) < used_cols);
		end
	end

	assign acc      = req_valid & req_ready;
	assign coord_in = (UCW'(req.col_x) < used_cols) && (URW'(req.row_y) < used_rows);
	assign ok_now   = ((req.action == lgs_pkg::ACT_WRITE) || (req.action == lgs_pkg::ACT_READ))
		? coord_in : 1'b1;

	assign col_ext = UCW'(item_q.col_x);
	assign row_ext = URW'(item_q.row_y);
	assign col_idx = col_ext[CAW-1:0];
	assign row_idx = row_ext[AW-1:0];

	// A row whose valid bit is clear reads as all dead.
	always_comb begin
		row_old = vld_s1 ? ram_rdata : '0;
		row_win = (rd_idx_s1 < RCW'(used_rows)) ? (row_old & col_mask) : '0;
		row_mod = row_old;
		row_mod[col_idx] = item_q.cell_value;
	end

	assign wr_idx    = win_idx_s2 - RCW'(1);
	assign step_done = win_v_s2 && (win_idx_s2 == RCW'(used_rows));

	lgs_row_rule #(
		.COLS(MAX_COLS)
	) u_rule (
		.above   (win_prev_q),
		.center  (win_cur_q),
		.below   (win_next_q),
		.col_mask(col_mask),
		.next_row(new_row)
	);

	lgs_ram #(
		.WIDTH(MAX_COLS),
		.DEPTH(MAX_ROWS)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lgs_pkg::ST_IDLE: begin
				if (acc) begin
					priority if (req.action == lgs_pkg::ACT_STEP) begin
						state_d = lgs_pkg::ST_STEP;
					end else if (req.action != lgs_pkg::ACT_CLEAR && coord_in) begin
						state_d = lgs_pkg::ST_CELL_RD;
					end else begin
						state_d = lgs_pkg::ST_FINISH;
					end
				end
			end
			lgs_pkg::ST_CELL_RD: state_d = lgs_pkg::ST_CELL_WB;
			lgs_pkg::ST_CELL_WB: state_d = lgs_pkg::ST_FINISH;
			lgs_pkg::ST_STEP: begin
				if (step_done) begin
					state_d = lgs_pkg::ST_FINISH;
				end
			end
			lgs_pkg::ST_FINISH: begin
				if (rsp_load) begin
					state_d = lgs_pkg::ST_IDLE;
				end
			end
			default: state_d = lgs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = (state_q == lgs_pkg::ST_IDLE);
		rd_issue  = (state_q == lgs_pkg::ST_STEP) && (rd_cnt_q <= RCW'(used_rows));
		rsp_load  = (state_q == lgs_pkg::ST_FINISH) && (!rsp_valid_q || rsp_ready);
		ram_raddr = (state_q == lgs_pkg::ST_STEP) ? rd_cnt_q[AW-1:0] : row_idx;
		ram_we    = 1'b0;
		ram_waddr = wr_idx[AW-1:0];
		ram_wdata = new_row;
		if (state_q == lgs_pkg::ST_CELL_WB && item_q.action == lgs_pkg::ACT_WRITE) begin
			ram_we    = 1'b1;
			ram_waddr = row_idx;
			ram_wdata = row_mod;
		end else if (state_q == lgs_pkg::ST_STEP && win_v_s2 && win_idx_s2 != '0) begin
			ram_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lgs_pkg::ST_IDLE;
			grid_w_q    <= lgs_pkg::GRID_SIZE_RST;
			grid_h_q    <= lgs_pkg::GRID_SIZE_RST;
			rd_cnt_q    <= '0;
			rd_v_s1     <= 1'b0;
			win_v_s2    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_v_s1  <= rd_issue;
			win_v_s2 <= rd_v_s1;
			if (cfg_we) begin
				unique case (cfg_idx)
					lgs_pkg::REG_GRID_WIDTH:  grid_w_q <= cfg_wdata;
					lgs_pkg::REG_GRID_HEIGHT: grid_h_q <= cfg_wdata;
				endcase
			end
			if (acc) begin
				rd_cnt_q <= '0;
			end else if (rd_issue) begin
				rd_cnt_q <= rd_cnt_q + RCW'(1);
			end
			priority if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end else begin
				rsp_valid_q <= rsp_valid_q;
			end
		end
	end

	// Rows at or beyond the used height are dropped when an advance finishes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (acc && req.action == lgs_pkg::ACT_CLEAR) begin
			row_vld_q <= '0;
		end else begin
			if (ram_we) begin
				row_vld_q[ram_waddr] <= 1'b1;
			end
			if (step_done) begin
				for (int r = 0; r < MAX_ROWS; r++) begin
					if (URW'(r) >= used_rows) begin
						row_vld_q[r] <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		vld_s1    <= row_vld_q[ram_raddr];
		rd_idx_s1 <= rd_cnt_q;
		if (acc) begin
			item_q      <= req;
			res_ok_q    <= ok_now;
			res_alive_q <= 1'b0;
			win_prev_q  <= '0;
			win_cur_q   <= '0;
			win_next_q  <= '0;
		end else begin
			if (state_q == lgs_pkg::ST_CELL_WB && item_q.action == lgs_pkg::ACT_READ) begin
				res_alive_q <= row_old[col_idx];
			end
			if (rd_v_s1) begin
				win_prev_q <= win_cur_q;
				win_cur_q  <= win_next_q;
				win_next_q <= row_win;
				win_idx_s2 <= rd_idx_s1;
			end
		end
		if (rsp_load) begin
			rsp_q.read_alive <= res_alive_q;
			rsp_q.coord_ok   <= res_ok_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: hw/rtl/lgs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lgs_ram #(
	parameter int WIDTH = lgs_pkg::MAX_COLS_DEF,
	parameter int DEPTH = lgs_pkg::MAX_ROWS_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/lgs_row_rule.sv
// Row-wide neighbor count and B3/S23 rule for one grid row.
module lgs_row_rule #(
	parameter int COLS = lgs_pkg::MAX_COLS_DEF
) (
	input  logic [COLS-1:0] above,
	input  logic [COLS-1:0] center,
	input  logic [COLS-1:0] below,
	input  logic [COLS-1:0] col_mask,
	output logic [COLS-1:0] next_row
);

	logic [COLS+1:0] pad_a;
	logic [COLS+1:0] pad_c;
	logic [COLS+1:0] pad_b;
	logic [3:0]      cnt [COLS];

	// Zero padding on both ends makes the left and right edges count as dead.
	always_comb begin
		pad_a = {1'b0, above, 1'b0};
		pad_c = {1'b0, center, 1'b0};
		pad_b = {1'b0, below, 1'b0};
		for (int c = 0; c < COLS; c++) begin
			cnt[c] = 4'(pad_a[c]) + 4'(pad_a[c+1]) + 4'(pad_a[c+2])
				+ 4'(pad_c[c]) + 4'(pad_c[c+2])
				+ 4'(pad_b[c]) + 4'(pad_b[c+1]) + 4'(pad_b[c+2]);
			next_row[c] = col_mask[c] & ((cnt[c] == lgs_pkg::BIRTH_COUNT)
				| (center[c] & (cnt[c] == lgs_pkg::SURVIVE_COUNT)));
		end
	end

endmodule

FILE: hw/rtl/lgs_checker.sv
// Port-level checker for the life grid generation step block, bound to the top level.
module lgs_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input lgs_pkg::rsp_t rsp
);

	// The block works on one item at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("block ready again right after taking an item");

	// No result can appear in the cycle right after an item is taken.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !$rose(rsp_valid))
		else $error("result appeared too early");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed or dropped");

	// An access outside the used area never reports a live cell.
	a_bad_coord_dead: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.coord_ok || !rsp.read_alive)
		else $error("live cell reported for a rejected access");

endmodule

bind life_grid_generation_step lgs_checker u_lgs_checker (.*);
